>>> rtl/core/fee_pkg.sv
// ----------------------------------------------------------------------------
// fee_pkg: shared constants and types
// Sizes, header codes, item kinds and status codes of the flash EEPROM
// emulation block.
// ----------------------------------------------------------------------------
package fee_pkg;

    localparam int PAGE_SLOTS = 1024;
    localparam int VARIABLES  = 256;

    localparam int SLOT_W  = $clog2(PAGE_SLOTS);
    localparam int FILL_W  = $clog2(PAGE_SLOTS + 1);
    localparam int ADDR_W  = $clog2(2 * PAGE_SLOTS);
    localparam int VAR_CW  = $clog2(VARIABLES + 1);
    localparam int WORD_W  = 32;

    localparam logic [15:0] HDR_ERASED  = 16'hFFFF;
    localparam logic [15:0] HDR_RECEIVE = 16'hEEEE;
    localparam logic [15:0] HDR_VALID   = 16'h0000;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_READ    = 2'd0;
    localparam kind_t KIND_WRITE   = 2'd1;
    localparam kind_t KIND_RECOVER = 2'd2;
    localparam kind_t KIND_NONE    = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_NO_PAGE   = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // page selection: 0, 1 or none
    typedef logic [1:0] page_sel_t;
    localparam page_sel_t PAGE_NONE = 2'd2;

endpackage

>>> rtl/core/fee_ram.sv
// ----------------------------------------------------------------------------
// fee_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/flash_eeprom_emulation_unit.sv
// ----------------------------------------------------------------------------
// flash_eeprom_emulation_unit: two-page flash EEPROM emulation
// Header states, append-only slots, scans, page transfer and recovery,
// all driven by one sequencer around one slot RAM and one compare.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: kind, var_address and value transfer at a rising edge
//   where start is high and busy is low. busy stays high until the result.
//   Result channel: done is high for exactly one cycle with read_data and
//   status; the receiver cannot stall, so the result must be taken then.
//   A read scans the valid page from its newest slot down, each slot taking
//   a RAM read, then a compare. A write that fits, or a recover that only
//   touches headers, finishes in the decode state. A page transfer or a
//   copying recover runs one such scan per variable.
//   One command at a time; the next may transfer at the edge that takes
//   the result.
//   Reset: both pages read as erased at once (per-page fill counters, no
//   clearing pass), busy and done low.
// ----------------------------------------------------------------------------
module flash_eeprom_emulation_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  fee_pkg::kind_t  kind,
    input  logic [7:0]      var_address,
    input  logic [15:0]     value,
    output logic            done,
    output logic [15:0]     read_data,
    output fee_pkg::status_t status
);
    import fee_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_T_APPEND, S_SKIP_RD, S_COPY, S_SCAN, S_CMP
    } state_t;

    typedef enum logic [1:0] {
        CTX_READ, CTX_XFER, CTX_REC0, CTX_REC1
    } ctx_t;

    state_t             state_reg, state_next;
    ctx_t               ctx_reg, ctx_next;
    kind_t              kind_reg, kind_next;
    logic [7:0]         addr_reg, addr_next;
    logic [15:0]        value_reg, value_next;
    logic [15:0]        skip_reg, skip_next;
    logic [15:0]        target_reg, target_next;
    logic [VAR_CW-1:0]  v_reg, v_next;
    logic [SLOT_W-1:0]  ptr_reg, ptr_next;
    logic               oldp_reg, oldp_next;
    logic [FILL_W-1:0]  fill_reg [2];
    logic [FILL_W-1:0]  fill_next [2];
    logic [15:0]        hdr_reg [2];
    logic [15:0]        hdr_next [2];
    logic               done_reg, done_next;
    logic [15:0]        rd_reg, rd_next;
    status_t            st_reg, st_next;

    page_sel_t          rp, wp;
    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [WORD_W-1:0]  wdata, rdata;
    logic [FILL_W-1:0]  rp_fill_m1;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic pg,
                                                    input logic [SLOT_W-1:0] s);
        logic [ADDR_W-1:0] base;
        base = pg ? ADDR_W'(PAGE_SLOTS) : '0;
        return base + ADDR_W'(s);
    endfunction

    // read page and write page from the current headers
    always_comb
    begin
        if (hdr_reg[0] == HDR_VALID)
            rp = 2'd0;
        else if (hdr_reg[1] == HDR_VALID)
            rp = 2'd1;
        else
            rp = PAGE_NONE;

        if (hdr_reg[1] == HDR_VALID)
            wp = (hdr_reg[0] == HDR_RECEIVE) ? 2'd0 : 2'd1;
        else if (hdr_reg[0] == HDR_VALID)
            wp = (hdr_reg[1] == HDR_RECEIVE) ? 2'd1 : 2'd0;
        else
            wp = PAGE_NONE;
    end

    assign rp_fill_m1 = fill_reg[rp[0]] - FILL_W'(1);

    fee_ram #(.WIDTH(WORD_W), .DEPTH(2 * PAGE_SLOTS)) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        ctx_next    = ctx_reg;
        kind_next   = kind_reg;
        addr_next   = addr_reg;
        value_next  = value_reg;
        skip_next   = skip_reg;
        target_next = target_reg;
        v_next      = v_reg;
        ptr_next    = ptr_reg;
        oldp_next   = oldp_reg;
        fill_next   = fill_reg;
        hdr_next    = hdr_reg;
        done_next   = 1'b0;
        rd_next     = rd_reg;
        st_next     = st_reg;
        we          = 1'b0;
        waddr       = slot_addr(wp[0], fill_reg[wp[0]][SLOT_W-1:0]);
        wdata       = '0;
        raddr       = slot_addr(rp[0], ptr_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    addr_next  = var_address;
                    value_next = value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                // default finish; branches that keep working override it
                state_next = S_IDLE;
                done_next  = 1'b1;
                rd_next    = '0;
                st_next    = ST_OK;
                unique case (kind_reg)
                    KIND_READ:
                    begin
                        if (rp == PAGE_NONE)
                        begin
                            st_next = ST_NO_PAGE;
                        end
                        else
                        begin
                            done_next   = 1'b0;
                            ctx_next    = CTX_READ;
                            target_next = 16'(addr_reg);
                            ptr_next    = rp_fill_m1[SLOT_W-1:0];
                            state_next  = S_SCAN;
                        end
                    end
                    KIND_WRITE:
                    begin
                        if (wp == PAGE_NONE)
                        begin
                            st_next = ST_NO_PAGE;
                        end
                        else if (fill_reg[wp[0]] != FILL_W'(PAGE_SLOTS))
                        begin
                            we    = 1'b1;
                            wdata = {16'(addr_reg), value_reg};
                            fill_next[wp[0]] = fill_reg[wp[0]] + FILL_W'(1);
                        end
                        else if (rp == PAGE_NONE)
                        begin
                            st_next = ST_NO_PAGE;
                        end
                        else
                        begin
                            // mark the other page receiving and start transfer
                            done_next = 1'b0;
                            oldp_next = rp[0];
                            hdr_next[~rp[0]] = hdr_reg[~rp[0]] & HDR_RECEIVE;
                            state_next = S_T_APPEND;
                        end
                    end
                    KIND_RECOVER:
                    begin
                        if (hdr_reg[0] == HDR_ERASED)
                        begin
                            if (hdr_reg[1] == HDR_VALID)
                            begin
                                fill_next[0] = FILL_W'(1);
                                hdr_next[0]  = HDR_ERASED;
                            end
                            else if (hdr_reg[1] == HDR_RECEIVE)
                            begin
                                fill_next[0] = FILL_W'(1);
                                hdr_next[0]  = HDR_ERASED;
                                hdr_next[1]  = hdr_reg[1] & HDR_VALID;
                            end
                            else
                            begin
                                fill_next[0] = FILL_W'(1);
                                fill_next[1] = FILL_W'(1);
                                hdr_next[0]  = HDR_VALID;
                                hdr_next[1]  = HDR_ERASED;
                            end
                        end
                        else if (hdr_reg[0] == HDR_RECEIVE)
                        begin
                            if (hdr_reg[1] == HDR_VALID)
                            begin
                                done_next  = 1'b0;
                                ctx_next   = CTX_REC0;
                                raddr      = slot_addr(1'b0, SLOT_W'(1));
                                state_next = S_SKIP_RD;
                            end
                            else if (hdr_reg[1] == HDR_ERASED)
                            begin
                                fill_next[1] = FILL_W'(1);
                                hdr_next[1]  = HDR_ERASED;
                                hdr_next[0]  = hdr_reg[0] & HDR_VALID;
                            end
                            else
                            begin
                                fill_next[0] = FILL_W'(1);
                                fill_next[1] = FILL_W'(1);
                                hdr_next[0]  = HDR_VALID;
                                hdr_next[1]  = HDR_ERASED;
                            end
                        end
                        else if (hdr_reg[0] == HDR_VALID)
                        begin
                            if (hdr_reg[1] == HDR_VALID)
                            begin
                                fill_next[0] = FILL_W'(1);
                                fill_next[1] = FILL_W'(1);
                                hdr_next[0]  = HDR_VALID;
                                hdr_next[1]  = HDR_ERASED;
                            end
                            else if (hdr_reg[1] == HDR_ERASED)
                            begin
                                fill_next[1] = FILL_W'(1);
                                hdr_next[1]  = HDR_ERASED;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                ctx_next   = CTX_REC1;
                                raddr      = slot_addr(1'b1, SLOT_W'(1));
                                state_next = S_SKIP_RD;
                            end
                        end
                        else
                        begin
                            fill_next[0] = FILL_W'(1);
                            fill_next[1] = FILL_W'(1);
                            hdr_next[0]  = HDR_VALID;
                            hdr_next[1]  = HDR_ERASED;
                        end
                    end
                    KIND_NONE:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end

            S_T_APPEND:
            begin
                // append the new value to the current write page, or report no page or full
                if (wp == PAGE_NONE)
                begin
                    done_next  = 1'b1;
                    rd_next    = '0;
                    st_next    = ST_NO_PAGE;
                    state_next = S_IDLE;
                end
                else if (fill_reg[wp[0]] == FILL_W'(PAGE_SLOTS))
                begin
                    done_next  = 1'b1;
                    rd_next    = '0;
                    st_next    = ST_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    we    = 1'b1;
                    wdata = {16'(addr_reg), value_reg};
                    fill_next[wp[0]] = fill_reg[wp[0]] + FILL_W'(1);
                    ctx_next   = CTX_XFER;
                    skip_next  = 16'(addr_reg);
                    v_next     = '0;
                    state_next = S_COPY;
                end
            end

            S_SKIP_RD:
            begin
                // skip the variable already in slot 1 of the target page
                if (ctx_reg == CTX_REC0)
                    skip_next = (fill_reg[0] > FILL_W'(1)) ? rdata[31:16] : 16'hFFFF;
                else
                    skip_next = (fill_reg[1] > FILL_W'(1)) ? rdata[31:16] : 16'hFFFF;
                v_next     = '0;
                state_next = S_COPY;
            end

            S_COPY:
            begin
                priority if (v_reg == VAR_CW'(VARIABLES))
                begin
                    // copy complete: retire the old page, validate the new one
                    unique case (ctx_reg)
                        CTX_REC0:
                        begin
                            hdr_next[0]  = hdr_reg[0] & HDR_VALID;
                            hdr_next[1]  = HDR_ERASED;
                            fill_next[1] = FILL_W'(1);
                        end
                        CTX_REC1:
                        begin
                            hdr_next[1]  = hdr_reg[1] & HDR_VALID;
                            hdr_next[0]  = HDR_ERASED;
                            fill_next[0] = FILL_W'(1);
                        end
                        CTX_XFER, CTX_READ:
                        begin
                            hdr_next[oldp_reg]   = HDR_ERASED;
                            fill_next[oldp_reg]  = FILL_W'(1);
                            hdr_next[~oldp_reg]  = hdr_reg[~oldp_reg] & HDR_VALID;
                        end
                    endcase
                    done_next  = 1'b1;
                    rd_next    = '0;
                    st_next    = ST_OK;
                    state_next = S_IDLE;
                end
                else if (16'(v_reg) == skip_reg || rp == PAGE_NONE)
                begin
                    v_next = v_reg + VAR_CW'(1);
                end
                else
                begin
                    target_next = 16'(v_reg);
                    ptr_next    = rp_fill_m1[SLOT_W-1:0];
                    state_next  = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue the read of the slot under the pointer, or end the scan at slot 0
                if (ptr_reg == '0)
                begin
                    if (ctx_reg == CTX_READ)
                    begin
                        done_next  = 1'b1;
                        rd_next    = '0;
                        st_next    = ST_NOT_FOUND;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        v_next     = v_reg + VAR_CW'(1);
                        state_next = S_COPY;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (rdata[31:16] == target_reg)
                begin
                    if (ctx_reg == CTX_READ)
                    begin
                        done_next  = 1'b1;
                        rd_next    = rdata[15:0];
                        st_next    = ST_OK;
                        state_next = S_IDLE;
                    end
                    else if (wp == PAGE_NONE ||
                             fill_reg[wp[0]] == FILL_W'(PAGE_SLOTS))
                    begin
                        done_next  = 1'b1;
                        rd_next    = '0;
                        st_next    = (wp == PAGE_NONE) ? ST_NO_PAGE : ST_FULL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        we    = 1'b1;
                        wdata = {target_reg, rdata[15:0]};
                        fill_next[wp[0]] = fill_reg[wp[0]] + FILL_W'(1);
                        v_next     = v_reg + VAR_CW'(1);
                        state_next = S_COPY;
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg - SLOT_W'(1);
                    state_next = S_SCAN;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state, page bookkeeping and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ctx_reg     <= CTX_READ;
            done_reg    <= 1'b0;
            fill_reg[0] <= FILL_W'(1);
            fill_reg[1] <= FILL_W'(1);
            hdr_reg[0]  <= HDR_ERASED;
            hdr_reg[1]  <= HDR_ERASED;
            rd_reg      <= '0;
            st_reg      <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            done_reg  <= done_next;
            fill_reg  <= fill_next;
            hdr_reg   <= hdr_next;
            rd_reg    <= rd_next;
            st_reg    <= st_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        addr_reg   <= addr_next;
        value_reg  <= value_next;
        skip_reg   <= skip_next;
        target_reg <= target_next;
        v_reg      <= v_next;
        ptr_reg    <= ptr_next;
        oldp_reg   <= oldp_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign read_data = rd_reg;
    assign status    = st_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> read_data == 16'h0000)
        else $error("nonzero read data on failed item");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[0] != '0 && fill_reg[1] != '0 &&
        fill_reg[0] <= FILL_W'(PAGE_SLOTS) && fill_reg[1] <= FILL_W'(PAGE_SLOTS))
        else $error("page fill count out of range");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted command did not start work");
`endif

endmodule
